### src/bfw_pkg.sv
// ----------------------------------------------------------------------------
// Bounded frequency window package
// Shared widths, default sizes and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bfw_pkg;

   localparam int VALUE_W         = 10;
   localparam int CFG_W           = 13;
   localparam int LEN_W           = 13;
   localparam int DEF_VALUE_RANGE = 1024;
   localparam int DEF_SEQ_DEPTH   = 4096;
   localparam int RECIP_SHIFT     = 20;

   localparam logic [CFG_W-1:0] MAX_REPEATS_RESET = CFG_W'(1);

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic incr;
      logic ev_rd;
      logic ev_wr;
      logic result;
      logic drain;
      logic restart;
   } bfw_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic full;
      logic last;
      logic over;
      logic match;
      logic win_empty;
      logic drain_pend;
      logic out_free;
   } bfw_status_type;

endpackage

`default_nettype wire

### src/bfw_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one sequence element and its end-of-sequence flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfw_req_if import bfw_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, value, last, input ready);
   modport sink   (input valid, value, last, output ready);

endinterface

`default_nettype wire

### src/bfw_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the running best window length and the sequence flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfw_rsp_if import bfw_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] best_length;
   logic             overflow;
   logic             done_res;

   modport source (output valid, best_length, overflow, done_res, input ready);
   modport sink   (input valid, best_length, overflow, done_res, output ready);

endinterface

`default_nettype wire

### src/bfw_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the write data of the repeat limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfw_csr_if import bfw_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);

endinterface

`default_nettype wire

### src/bfw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfw_ram import bfw_pkg::*; #(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = DEF_SEQ_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/bfw_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded frequency window controller
// Sequences the count table clear, the add and evict steps of each element,
// the result transfer and the drain that closes a sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module bfw_ctrl import bfw_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  var  bfw_status_type stat,
   output bfw_cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_READ   = 8'b0000_0100,
      ST_INC    = 8'b0000_1000,
      ST_EV_CNT = 8'b0001_0000,
      ST_EV_WR  = 8'b0010_0000,
      ST_RESULT = 8'b0100_0000,
      ST_DRAIN  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.full ? ST_RESULT : ST_READ;
            end
         end
         ST_READ: begin
            cmd.load = 1'b1;
            state_in = ST_INC;
         end
         ST_INC: begin
            cmd.incr = 1'b1;
            state_in = stat.over ? ST_EV_CNT : ST_RESULT;
         end
         ST_EV_CNT: begin
            cmd.ev_rd = 1'b1;
            state_in  = ST_EV_WR;
         end
         ST_EV_WR: begin
            cmd.ev_wr = 1'b1;
            state_in  = stat.match ? ST_RESULT : ST_EV_CNT;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.result = 1'b1;
               state_in   = stat.last ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (stat.win_empty && !stat.drain_pend) begin
               cmd.restart = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/bfw_datapath.sv
// ----------------------------------------------------------------------------
// Bounded frequency window datapath
// Holds the window pointers, the count table, the history buffer, the repeat
// limit register and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfw_datapath import bfw_pkg::*; #(
   parameter int VALUE_RANGE = DEF_VALUE_RANGE,
   parameter int SEQ_DEPTH   = DEF_SEQ_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic               req_last,
   bfw_csr_if.sink                 csr_bus,
   bfw_rsp_if.source               rsp_bus,
   input  var  bfw_cmd_type        cmd,
   output bfw_status_type          stat
);

   localparam int VAW   = $clog2(VALUE_RANGE);
   localparam int HAW   = $clog2(SEQ_DEPTH);
   localparam int PW    = $clog2(SEQ_DEPTH + 1);
   localparam int CMPW  = (PW > CFG_W) ? PW : CFG_W;
   localparam int RECIP = (1 << RECIP_SHIFT) / VALUE_RANGE;
   localparam int PRODW = VALUE_W + RECIP_SHIFT + 1;
   localparam int VRW   = $clog2(VALUE_RANGE + 1);
   localparam int QVW   = VALUE_W + VRW;

   logic [CFG_W-1:0]   mr_ff, mr_in;
   logic [PW-1:0]      right_ff, right_in;
   logic [PW-1:0]      left_ff, left_in;
   logic [PW-1:0]      best_ff, best_in;
   logic               ovf_ff, ovf_in;
   logic [VAW-1:0]     clr_ff, clr_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [VAW-1:0]     vmod_ff, vmod_in;
   logic [VAW-1:0]     old_ff, old_in;
   logic [LEN_W-1:0]   rsp_best_ff, rsp_best_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [PRODW-1:0]       prod;
   logic [QVW-1:0]         qv;
   logic [QVW-1:0]         rem;
   logic [QVW-1:0]         rem_fix;
   logic [VAW-1:0]         r_mod;
   logic [CFG_W-1:0]       limit;
   logic [PW-1:0]          cnt_rd;
   logic [PW-1:0]          cnt_inc;
   logic [PW-1:0]          cnt_dec;
   logic [VAW-1:0]         hist_rd;
   logic [PW-1:0]          left_nx;
   logic [PW-1:0]          win_len;
   logic [PW-1:0]          best_new;
   logic [LEN_W+PW-1:0]    best_ext;
   logic                   win_empty;
   logic                   full;

   logic                   cnt_we;
   logic [VAW-1:0]         cnt_waddr;
   logic [PW-1:0]          cnt_wdata;
   logic [VAW-1:0]         cnt_raddr;
   logic [HAW-1:0]         hist_raddr;

   // Values are reduced into the table range by a reciprocal multiply whose
   // quotient is never more than one too small, then one correcting subtract.
   assign prod    = PRODW'(req_value) * PRODW'(RECIP);
   assign qv      = QVW'(quot_ff) * QVW'(VALUE_RANGE);
   assign rem     = QVW'(value_ff) - qv;
   assign rem_fix = (rem >= QVW'(VALUE_RANGE)) ? rem - QVW'(VALUE_RANGE) : rem;
   assign r_mod   = rem_fix[VAW-1:0];

   assign limit     = (mr_ff == '0) ? CFG_W'(1) : mr_ff;
   assign cnt_inc   = cnt_rd + PW'(1);
   assign cnt_dec   = cnt_rd - PW'(1);
   assign left_nx   = left_ff + PW'(1);
   assign win_len   = right_ff - left_ff;
   assign best_new  = (win_len > best_ff) ? win_len : best_ff;
   assign best_ext  = {{LEN_W{1'b0}}, best_new};
   assign win_empty = (left_ff == right_ff);
   assign full      = (right_ff == PW'(SEQ_DEPTH));

   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = vmod_ff;
      cnt_wdata = '0;
      if (cmd.clear) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
      end else if (cmd.incr) begin
         cnt_we    = 1'b1;
         cnt_wdata = cnt_inc;
      end else if (cmd.ev_wr) begin
         cnt_we    = 1'b1;
         cnt_waddr = old_ff;
         cnt_wdata = cnt_dec;
      end else if (cmd.drain && pend_ff) begin
         cnt_we    = 1'b1;
         cnt_waddr = hist_rd;
      end
   end

   assign cnt_raddr  = cmd.load ? r_mod : hist_rd;
   assign hist_raddr = cmd.ev_wr ? left_nx[HAW-1:0] : left_ff[HAW-1:0];

   bfw_ram #(
      .WIDTH (PW),
      .DEPTH (VALUE_RANGE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   bfw_ram #(
      .WIDTH (VAW),
      .DEPTH (SEQ_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (right_ff[HAW-1:0]),
      .wr_data (r_mod),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   always_comb begin
      mr_in        = mr_ff;
      right_in     = right_ff;
      left_in      = left_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      quot_in      = quot_ff;
      vmod_in      = vmod_ff;
      old_in       = old_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_done_in  = rsp_done_ff;

      if (csr_bus.valid) begin
         mr_in = csr_bus.data;
      end
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.clear) begin
         clr_in = clr_ff + VAW'(1);
      end
      if (cmd.accept) begin
         value_in = req_value;
         last_in  = req_last;
         quot_in  = prod[RECIP_SHIFT +: VALUE_W];
         if (full) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load) begin
         vmod_in = r_mod;
      end
      if (cmd.incr) begin
         right_in = right_ff + PW'(1);
      end
      if (cmd.ev_rd) begin
         old_in = hist_rd;
      end
      if (cmd.ev_wr) begin
         left_in = left_nx;
      end
      if (cmd.result) begin
         best_in      = best_new;
         rsp_valid_in = 1'b1;
         rsp_best_in  = best_ext[LEN_W-1:0];
         rsp_ovf_in   = ovf_ff;
         rsp_done_in  = last_ff;
      end
      if (cmd.drain) begin
         pend_in = !win_empty;
         if (!win_empty) begin
            left_in = left_nx;
         end
      end
      if (cmd.restart) begin
         right_in = '0;
         left_in  = '0;
         best_in  = '0;
         ovf_in   = 1'b0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mr_ff        <= MAX_REPEATS_RESET;
         right_ff     <= '0;
         left_ff      <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mr_ff        <= mr_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      last_ff     <= last_in;
      quot_ff     <= quot_in;
      vmod_ff     <= vmod_in;
      old_ff      <= old_in;
      rsp_best_ff <= rsp_best_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.best_length = rsp_best_ff;
   assign rsp_bus.overflow    = rsp_ovf_ff;
   assign rsp_bus.done_res    = rsp_done_ff;

   // Eviction stops once an evicted element is the new value and its count is
   // back within the limit, which also covers a limit lowered mid-sequence.
   assign stat.clear_done = (clr_ff == VAW'(VALUE_RANGE - 1));
   assign stat.full       = full;
   assign stat.last       = last_ff;
   assign stat.over       = (CMPW'(cnt_inc) > CMPW'(limit));
   assign stat.match      = (old_ff == vmod_ff) && !(CMPW'(cnt_dec) > CMPW'(limit));
   assign stat.win_empty  = win_empty;
   assign stat.drain_pend = pend_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_bus.ready;

endmodule

`default_nettype wire

### src/bounded_frequency_window.sv
// ----------------------------------------------------------------------------
// Bounded frequency window
// Tracks the longest run of a value sequence in which no value repeats more
// than the programmed limit.
// ----------------------------------------------------------------------------
// After reset the block clears its count table, one entry per cycle, before
// it takes the first element; configuration writes are taken at any time.
// Each element steps through transfer, count table read, count update and
// result, which waits for a free response register, plus an evict read and
// write for every element it evicts, since every count update is a read and
// a write of the single count table. An element that arrives after SEQ_DEPTH
// elements of its sequence goes straight to result. An element that ends a
// sequence is followed by a drain that clears the count of each element
// still in the window, during which no element is taken. The response
// register lets the next element enter while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_frequency_window import bfw_pkg::*; #(
   parameter int VALUE_RANGE = DEF_VALUE_RANGE,
   parameter int SEQ_DEPTH   = DEF_SEQ_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   bfw_req_if.sink   req_bus,
   bfw_rsp_if.source rsp_bus,
   bfw_csr_if.sink   csr_bus
);

   bfw_cmd_type    cmd;
   bfw_status_type stat;
   logic           req_ready;

   bfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   bfw_datapath #(
      .VALUE_RANGE (VALUE_RANGE),
      .SEQ_DEPTH   (SEQ_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_bus.value),
      .req_last  (req_bus.last),
      .csr_bus   (csr_bus),
      .rsp_bus   (rsp_bus),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

### src/bfw_checker.sv
// ----------------------------------------------------------------------------
// Bounded frequency window checker
// Watches the top level ports and checks the request handshake and response ordering rules.
// ----------------------------------------------------------------------------
`default_nettype none

module bfw_checker import bfw_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [LEN_W-1:0] rsp_best_length,
   input wire logic             rsp_overflow,
   input wire logic             rsp_done_res
);

   logic             rsp_xfer;
   logic             seen_ff, seen_in;
   logic             prev_done_ff, prev_done_in;
   logic             prev_ovf_ff, prev_ovf_in;
   logic [LEN_W-1:0] prev_best_ff, prev_best_in;

   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      seen_in      = seen_ff;
      prev_done_in = prev_done_ff;
      prev_ovf_in  = prev_ovf_ff;
      prev_best_in = prev_best_ff;
      if (rsp_xfer) begin
         seen_in      = 1'b1;
         prev_done_in = rsp_done_res;
         prev_ovf_in  = rsp_overflow;
         prev_best_in = rsp_best_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         prev_done_ff <= 1'b0;
         prev_ovf_ff  <= 1'b0;
         prev_best_ff <= '0;
      end else begin
         seen_ff      <= seen_in;
         prev_done_ff <= prev_done_in;
         prev_ovf_ff  <= prev_ovf_in;
         prev_best_ff <= prev_best_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response dropped before its transfer.");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while the previous element is in work.");

   a_best_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff && !prev_done_ff |-> rsp_best_length >= prev_best_ff)
      else $error("Best length fell within a sequence.");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff && !prev_done_ff && prev_ovf_ff |-> rsp_overflow)
      else $error("Overflow flag cleared within a sequence.");

endmodule

bind bounded_frequency_window bfw_checker u_bfw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_best_length (rsp_bus.best_length),
   .rsp_overflow    (rsp_bus.overflow),
   .rsp_done_res    (rsp_bus.done_res)
);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// Bounded frequency window testbench
// Drives element sequences and repeat limits into the block and checks every
// result against a cycle-free predictor of the window. It starts with short
// directed sequences, then random sequences under changing idle patterns on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bfw_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic             overflow;
      logic             done_res;
   } window_result_type;

   class window_scoreboard_type;
      bit [LEN_W-1:0]    counts [DEF_VALUE_RANGE];
      bit [VALUE_W-1:0]  history [DEF_SEQ_DEPTH];
      int unsigned       left_idx;
      int unsigned       right_idx;
      bit [LEN_W-1:0]    best_len;
      bit                over_seen;
      bit [CFG_W-1:0]    repeat_limit;
      window_result_type expected_q [$];
      int                error_count;

      function new();
         repeat_limit = MAX_REPEATS_RESET;
         error_count  = 0;
         restart();
      endfunction

      function void restart();
         foreach (counts[i]) counts[i] = '0;
         left_idx  = 0;
         right_idx = 0;
         best_len  = '0;
         over_seen = 1'b0;
      endfunction

      function void set_limit(input logic [CFG_W-1:0] data);
         repeat_limit = data;
      endfunction

      function void note_input(input logic [VALUE_W-1:0] value, input logic last);
         int unsigned       idx;
         int unsigned       lim;
         bit [VALUE_W-1:0]  oldest;
         window_result_type res;
         idx = value % DEF_VALUE_RANGE;
         lim = (repeat_limit == '0) ? 1 : 32'(repeat_limit);
         if (right_idx >= DEF_SEQ_DEPTH) begin
            over_seen = 1'b1;
         end else begin
            history[right_idx] = idx[VALUE_W-1:0];
            counts[idx]++;
            right_idx++;
            while (counts[idx] > lim && left_idx < right_idx) begin
               oldest = history[left_idx % DEF_SEQ_DEPTH];
               if (counts[oldest] > 0) counts[oldest]--;
               left_idx++;
            end
            if (right_idx - left_idx > best_len) best_len = LEN_W'(right_idx - left_idx);
         end
         res.best_length = best_len;
         res.overflow    = over_seen;
         res.done_res    = last;
         expected_q.push_back(res);
         if (last) restart();
      endfunction

      task report_mismatch(input string msg);
         error_count++;
         $display("%0t ns mismatch: %s", $time, msg);
      endtask

      task check_result(input window_result_type got);
         window_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %p", got));
         end else begin
            want = expected_q.pop_front();
            if (got.best_length !== want.best_length)
               report_mismatch($sformatf("best_length %0d, expected %0d",
                                         got.best_length, want.best_length));
            if (got.overflow !== want.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         got.overflow, want.overflow));
            if (got.done_res !== want.done_res)
               report_mismatch($sformatf("done_res %b, expected %b",
                                         got.done_res, want.done_res));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   results_seen;

   window_scoreboard_type sb = new();

   bfw_req_if req_bus();
   bfw_rsp_if rsp_bus();
   bfw_csr_if csr_bus();

   bounded_frequency_window dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      window_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_input(req_bus.value, req_bus.last);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.best_length = rsp_bus.best_length;
            got.overflow    = rsp_bus.overflow;
            got.done_res    = rsp_bus.done_res;
            sb.check_result(got);
            results_seen++;
         end
      end
   end

   // The receiver stalls once for a long stretch so that the block backs up.
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 150) begin
            held      = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.last  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_sequence(input int len, input int alphabet);
      int                 i;
      logic [VALUE_W-1:0] base;
      base = VALUE_W'($urandom_range(DEF_VALUE_RANGE - alphabet));
      for (i = 0; i < len; i++)
         send_element(VALUE_W'(base + $urandom_range(alphabet - 1)), i == len - 1);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      sb.set_limit(data);
   endtask

   function automatic logic [CFG_W-1:0] pick_limit();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return CFG_W'(4096);
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      int mode;
      int blk;
      int sent;
      int len;
      int alphabet;
      results_seen  = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last  <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset limit of one.
      send_element(10'd0, 1'b1);
      send_element(10'd1023, 1'b0);
      send_element(10'd1023, 1'b0);
      send_element(10'd0, 1'b0);
      send_element(10'd1023, 1'b0);
      send_element(10'd5, 1'b0);
      send_element(10'h2AA, 1'b0);
      send_element(10'h155, 1'b0);
      send_element(10'd5, 1'b1);
      wait_drained();
      write_limit('0);
      send_element(10'd7, 1'b0);
      send_element(10'd7, 1'b0);
      send_element(10'd7, 1'b0);
      send_element(10'd7, 1'b1);
      wait_drained();
      write_limit(CFG_W'(2));
      send_element(10'd3, 1'b0);
      send_element(10'd3, 1'b0);
      send_element(10'd3, 1'b0);
      send_element(10'd4, 1'b0);
      send_element(10'd3, 1'b0);
      send_element(10'd3, 1'b1);
      wait_drained();
      write_limit('1);
      send_element(10'd1, 1'b0);
      send_element(10'd1, 1'b0);
      send_element(10'd1, 1'b0);
      send_element(10'd1, 1'b1);

      for (mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 60 : 0;
         recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 8 : 0;
         for (blk = 0; blk < 4; blk++) begin
            wait_drained();
            write_limit(pick_limit());
            sent = 0;
            while (sent < 48) begin
               len      = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 30);
               alphabet = ($urandom_range(4) == 0) ? DEF_VALUE_RANGE
                                                   : $urandom_range(1, 6);
               send_sequence(len, alphabet);
               sent += len;
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
